// ===== hdl/mups_pkg.sv =====
// Shared types, widths and register codes for the max-unpool scatter address block.
package mups_pkg;

  // Payload widths
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 32;
  localparam int ADDR_W      = 32;

  // Configuration register widths
  localparam int DIM_REG_W   = 13;
  localparam int BIG_REG_W   = 17;
  localparam int SCALE_REG_W = 5;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // Plane bookkeeping
  localparam int PLANE_W     = 16;
  localparam int PLANE_LIMIT = 65536;
  localparam int AREA_W      = 33;

  // Parameter defaults
  localparam int DEF_MAX_DIM   = 4096;
  localparam int DEF_MAX_SCALE = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Divider: quotient bits resolved per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = IDX_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH      = 4'd0,
    REG_IN_HEIGHT     = 4'd1,
    REG_PLANE_COUNT   = 4'd2,
    REG_OUT_WIDTH     = 4'd3,
    REG_OUT_HEIGHT    = 4'd4,
    REG_SCALE_X       = 4'd5,
    REG_SCALE_Y       = 4'd6,
    REG_RELATIVE_MODE = 4'd7
  } cfg_reg_t;

  // Clamped settings plus precomputed plane size and absolute bound
  typedef struct packed {
    logic [DIM_REG_W-1:0]   in_width;
    logic [DIM_REG_W-1:0]   in_height;
    logic [BIG_REG_W-1:0]   plane_count;
    logic [BIG_REG_W-1:0]   out_width;
    logic [BIG_REG_W-1:0]   out_height;
    logic [SCALE_REG_W-1:0] scale_x;
    logic [SCALE_REG_W-1:0] scale_y;
    logic                   relative_mode;
    logic [AREA_W-1:0]      area;   // out_width * out_height
    logic [AREA_W-1:0]      bound;  // plane_count * area, saturated at 2**32
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_ROW,
    BK_MUL,
    BK_SUM
  } back_state_t;

endpackage

// ===== hdl/mups_if.sv =====
// Channel interfaces: configuration writes, input elements and scatter writes.
interface mups_cfg_if import mups_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface mups_in_if import mups_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;
  logic [IDX_W-1:0]  pool_index;

  modport source (output valid, output value, output pool_index, input ready);
  modport sink (input valid, input value, input pool_index, output ready);
endinterface

interface mups_out_if import mups_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [DATA_W-1:0] write_value;
  logic              out_of_range;
  logic              last;

  modport source (output valid, output write_address, output write_value,
                  output out_of_range, output last, input ready);
  modport sink (input valid, input write_address, input write_value,
                input out_of_range, input last, output ready);
endinterface

// ===== hdl/mups_cfg.sv =====
// Configuration registers, clamping and plane size products.
module mups_cfg import mups_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic     clk,
  input  logic     rst,
  mups_cfg_if.sink cfg,
  output cfg_t     settings,
  output logic     hold
);

  logic [DIM_REG_W-1:0]   in_width;
  logic [DIM_REG_W-1:0]   in_height;
  logic [BIG_REG_W-1:0]   plane_count;
  logic [BIG_REG_W-1:0]   out_width;
  logic [BIG_REG_W-1:0]   out_height;
  logic [SCALE_REG_W-1:0] scale_x;
  logic [SCALE_REG_W-1:0] scale_y;
  logic                   relative_mode;

  logic [1:0]             settle;
  logic [AREA_W-1:0]      area;
  logic [AREA_W-1:0]      bound;
  logic [2*BIG_REG_W-1:0] area_next;
  logic [IDX_W+BIG_REG_W-1:0] bound_prod;
  cfg_t                   clamped;

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_width      <= DIM_REG_W'(1);
      in_height     <= DIM_REG_W'(1);
      plane_count   <= BIG_REG_W'(1);
      out_width     <= BIG_REG_W'(1);
      out_height    <= BIG_REG_W'(1);
      scale_x       <= SCALE_REG_W'(2);
      scale_y       <= SCALE_REG_W'(2);
      relative_mode <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_IN_WIDTH:      in_width      <= cfg.data[DIM_REG_W-1:0];
        REG_IN_HEIGHT:     in_height     <= cfg.data[DIM_REG_W-1:0];
        REG_PLANE_COUNT:   plane_count   <= cfg.data[BIG_REG_W-1:0];
        REG_OUT_WIDTH:     out_width     <= cfg.data[BIG_REG_W-1:0];
        REG_OUT_HEIGHT:    out_height    <= cfg.data[BIG_REG_W-1:0];
        REG_SCALE_X:       scale_x       <= cfg.data[SCALE_REG_W-1:0];
        REG_SCALE_Y:       scale_y       <= cfg.data[SCALE_REG_W-1:0];
        REG_RELATIVE_MODE: relative_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Clamp every size to its legal range; zero acts as one
  always_comb begin
    clamped = '0;
    if (in_width == '0) clamped.in_width = DIM_REG_W'(1);
    else if (int'(in_width) > MAX_DIM) clamped.in_width = DIM_REG_W'(MAX_DIM);
    else clamped.in_width = in_width;

    if (in_height == '0) clamped.in_height = DIM_REG_W'(1);
    else if (int'(in_height) > MAX_DIM) clamped.in_height = DIM_REG_W'(MAX_DIM);
    else clamped.in_height = in_height;

    if (plane_count == '0) clamped.plane_count = BIG_REG_W'(1);
    else if (int'(plane_count) > PLANE_LIMIT) clamped.plane_count = BIG_REG_W'(PLANE_LIMIT);
    else clamped.plane_count = plane_count;

    if (out_width == '0) clamped.out_width = BIG_REG_W'(1);
    else if (int'(out_width) > PLANE_LIMIT) clamped.out_width = BIG_REG_W'(PLANE_LIMIT);
    else clamped.out_width = out_width;

    if (out_height == '0) clamped.out_height = BIG_REG_W'(1);
    else if (int'(out_height) > PLANE_LIMIT) clamped.out_height = BIG_REG_W'(PLANE_LIMIT);
    else clamped.out_height = out_height;

    if (scale_x == '0) clamped.scale_x = SCALE_REG_W'(1);
    else if (int'(scale_x) > MAX_SCALE) clamped.scale_x = SCALE_REG_W'(MAX_SCALE);
    else clamped.scale_x = scale_x;

    if (scale_y == '0) clamped.scale_y = SCALE_REG_W'(1);
    else if (int'(scale_y) > MAX_SCALE) clamped.scale_y = SCALE_REG_W'(MAX_SCALE);
    else clamped.scale_y = scale_y;

    clamped.relative_mode = relative_mode;
    clamped.area          = area;
    clamped.bound         = bound;
  end

  assign settings = clamped;

  // Plane size, then total output size saturated at 2**32
  assign area_next  = (2*BIG_REG_W)'(clamped.out_width) * (2*BIG_REG_W)'(clamped.out_height);
  assign bound_prod = (IDX_W+BIG_REG_W)'(clamped.plane_count) * (IDX_W+BIG_REG_W)'(area[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    area <= area_next[AREA_W-1:0];
    if (area[IDX_W] || (|bound_prod[IDX_W+BIG_REG_W-1:IDX_W])) begin
      bound <= {1'b1, {IDX_W{1'b0}}};
    end else begin
      bound <= {1'b0, bound_prod[IDX_W-1:0]};
    end
  end

  // Hold input while the products catch up with a write
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 2'd2;
    end else if (cfg.valid) begin
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign hold = cfg.valid || (settle != 2'd0);

endmodule

// ===== hdl/mups_front.sv =====
// Front end: takes elements, tracks raster position and plane base, tags the last one.
module mups_front import mups_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int CW      = $clog2(MAX_DIM),
  localparam int ENTRY_W = DATA_W + IDX_W + ADDR_W + 2*CW + 1
) (
  input  logic               clk,
  input  logic               rst,
  mups_in_if.sink            element,
  input  cfg_t               settings,
  input  logic               hold,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);

  logic [CW-1:0]      column;
  logic [CW-1:0]      row;
  logic [PLANE_W-1:0] plane;
  logic [ADDR_W-1:0]  plane_base;

  logic               end_col;
  logic               end_row;
  logic               end_pln;
  logic               last;
  logic               accept;
  logic [ADDR_W+1:0]  base_sum;

  // Classify position against the clamped sizes
  always_comb begin
    end_col  = (BIG_REG_W'(column) + BIG_REG_W'(1)) >= BIG_REG_W'(settings.in_width);
    end_row  = (BIG_REG_W'(row) + BIG_REG_W'(1)) >= BIG_REG_W'(settings.in_height);
    end_pln  = (BIG_REG_W'(plane) + BIG_REG_W'(1)) >= settings.plane_count;
    last     = end_col && end_row && end_pln;
    base_sum = (ADDR_W+2)'(plane_base) + (ADDR_W+2)'(settings.area);
  end

  assign element.ready = push_ready && !hold;
  assign push_valid    = element.valid && !hold;
  assign accept        = push_valid && push_ready;
  assign push_data     = {element.value, element.pool_index, plane_base, row, column, last};

  // Advance column, row and plane counters per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row        <= '0;
      plane      <= '0;
      plane_base <= '0;
    end else if (accept) begin
      if (!end_col) begin
        column <= column + CW'(1);
      end else begin
        column <= '0;
        if (!end_row) begin
          row <= row + CW'(1);
        end else begin
          row <= '0;
          if (!end_pln) begin
            plane <= plane + PLANE_W'(1);
            if (|base_sum[ADDR_W+1:ADDR_W]) plane_base <= '1;
            else plane_base <= base_sum[ADDR_W-1:0];
          end else begin
            plane      <= '0;
            plane_base <= '0;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/mups_queue.sv =====
// Small FIFO that decouples the front end from the back end.
module mups_queue import mups_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == DEPTH-1) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == DEPTH-1) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) count <= count + (AW+1)'(1);
      else if (do_pop && !do_push) count <= count - (AW+1)'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("queue occupancy above depth");

  a_no_pop_empty_move: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && !push_valid) |=> (rd_ptr == $past(rd_ptr)))
    else $error("read pointer moved on an empty queue");

endmodule

// ===== hdl/mups_back.sv =====
// Back end: window division, address arithmetic, range check and output register.
module mups_back import mups_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int MAX_SCALE = DEF_MAX_SCALE,
  localparam int CW      = $clog2(MAX_DIM),
  localparam int ENTRY_W = DATA_W + IDX_W + ADDR_W + 2*CW + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               settings,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  mups_out_if.source         scatter
);

  localparam int SW_RAW = $clog2(MAX_SCALE + 1);
  localparam int SW     = (SW_RAW < SCALE_REG_W) ? SW_RAW : SCALE_REG_W;
  localparam int RW     = SW + 1;
  localparam int RSW    = CW + SCALE_REG_W;
  localparam int OCW    = CW + SCALE_REG_W + 1;
  localparam int WIN_W  = 2 * SCALE_REG_W;
  localparam int ROW_W  = IDX_W + 1;
  localparam int PROD_W = IDX_W + BIG_REG_W;
  localparam int SUM_W  = PROD_W + 1;

  back_state_t state;
  back_state_t state_next;

  // Item held by the back end
  logic [DATA_W-1:0] value;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] base;
  logic [CW-1:0]     row;
  logic [CW-1:0]     column;
  logic              last;

  // Divider and arithmetic registers
  logic [IDX_W-1:0]  quot;
  logic [RW-1:0]     rem;
  logic [STEP_W-1:0] div_step;
  logic [ROW_W-1:0]  orow;
  logic [OCW-1:0]    ocol;
  logic              win_bad;
  logic [PROD_W-1:0] prod;
  logic              orow_ovf;
  logic              rel_bad;

  // Output register
  logic              out_valid;
  logic [ADDR_W-1:0] out_address;
  logic [DATA_W-1:0] out_value;
  logic              out_bad;
  logic              out_last;

  logic              out_load;
  logic [IDX_W-1:0]  quot_next;
  logic [RW-1:0]     rem_next;
  logic [RSW-1:0]    row_scaled;
  logic [WIN_W-1:0]  win_size;
  logic [SUM_W-1:0]  addr_sum;
  logic [ADDR_W-1:0] rel_address;
  logic              abs_bad;
  logic [RW-1:0]     divisor;

  assign divisor = RW'(settings.scale_x[SW-1:0]);

  // Resolve DIV_BITS quotient bits of pool_index / scale_x
  always_comb begin
    logic [IDX_W-1:0] q;
    logic [RW-1:0]    r;
    q = quot;
    r = rem;
    for (int k = 0; k < DIV_BITS; k++) begin
      r = {r[RW-2:0], q[IDX_W-1]};
      q = {q[IDX_W-2:0], 1'b0};
      if (r >= divisor) begin
        r    = r - divisor;
        q[0] = 1'b1;
      end
    end
    quot_next = q;
    rem_next  = r;
  end

  // Address pieces
  always_comb begin
    row_scaled  = RSW'(row) * RSW'(settings.scale_y);
    win_size    = WIN_W'(settings.scale_x) * WIN_W'(settings.scale_y);
    addr_sum    = SUM_W'(base) + SUM_W'(prod) + SUM_W'(ocol);
    rel_address = (orow_ovf || (|addr_sum[SUM_W-1:ADDR_W])) ? '1 : addr_sum[ADDR_W-1:0];
    abs_bad     = (AREA_W'(idx)) >= settings.bound;
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // Next state and handshakes
  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_next = BK_DIV;
      end
      BK_DIV: begin
        if (int'(div_step) == DIV_STEPS-1) state_next = BK_ROW;
      end
      BK_ROW: state_next = BK_MUL;
      BK_MUL: state_next = BK_SUM;
      BK_SUM: begin
        if (!out_valid || scatter.ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      div_step <= '0;
    end else if (state == BK_IDLE) begin
      div_step <= '0;
    end else if (state == BK_DIV) begin
      div_step <= div_step + STEP_W'(1);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && pop_valid) begin
      {value, idx, base, row, column, last} <= pop_data;
      quot <= pop_data[ENTRY_W-DATA_W-1 -: IDX_W];
      rem  <= '0;
    end
    if (state == BK_DIV) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
    if (state == BK_ROW) begin
      orow    <= ROW_W'(row_scaled) + ROW_W'(quot);
      ocol    <= OCW'(column) * OCW'(settings.scale_x) + OCW'(rem);
      win_bad <= idx >= IDX_W'(win_size);
    end
    if (state == BK_MUL) begin
      prod     <= PROD_W'(orow[IDX_W-1:0]) * PROD_W'(settings.out_width);
      orow_ovf <= orow[IDX_W];
      rel_bad  <= win_bad || (ROW_W'(ocol) >= ROW_W'(settings.out_width))
                  || (orow >= ROW_W'(settings.out_height));
    end
    if (out_load) begin
      out_value <= value;
      out_last  <= last;
      if (settings.relative_mode) begin
        out_address <= rel_address;
        out_bad     <= rel_bad;
      end else begin
        out_address <= idx;
        out_bad     <= abs_bad;
      end
    end
  end

  // Output valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (scatter.ready) out_valid <= 1'b0;
  end

  assign scatter.valid         = out_valid;
  assign scatter.write_address = out_address;
  assign scatter.write_value   = out_value;
  assign scatter.out_of_range  = out_bad;
  assign scatter.last          = out_last;

  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    (state == BK_ROW) |->
      ((38'(quot) * 38'(divisor) + 38'(rem)) == 38'(idx)) && (rem < divisor))
    else $error("window division result inconsistent");

  a_sum_waits: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SUM && out_valid && !scatter.ready) |=> (state == BK_SUM))
    else $error("result overwrote a pending transaction");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> (state == BK_DIV && div_step == '0))
    else $error("divider did not start from a fresh item");

endmodule

// ===== hdl/max_unpool_scatter_address.sv =====
// Max-unpool scatter address generator top level.
// Elements arrive in raster order (column, row, plane) and each yields one scatter write:
// the element word, its output address, a drop flag and a mark on the final element of the
// final plane. In relative mode the address is plane base + (row*scale_y + idx/scale_x)
// * out_width + col*scale_x + idx%scale_x, saturated at all ones; in absolute mode it is
// the index itself. The front end takes one element per cycle into a four-entry queue,
// unless input is held or the queue is full; the back end takes one element at a time from
// the queue, runs it through the divider for idx/scale_x (four quotient bits per cycle),
// two multiply stages and one final add before the output register, and takes no new element
// until the result is loaded there. After reset and after every configuration write, input
// is held while the output plane size and total output size are recomputed.
module max_unpool_scatter_address import mups_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic       clk,
  input  logic       rst,
  mups_cfg_if.sink   cfg,
  mups_in_if.sink    element,
  mups_out_if.source scatter
);

  localparam int CW      = $clog2(MAX_DIM);
  localparam int ENTRY_W = DATA_W + IDX_W + ADDR_W + 2*CW + 1;

  cfg_t               settings;
  logic               hold;
  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  mups_cfg #(
    .MAX_DIM   (MAX_DIM),
    .MAX_SCALE (MAX_SCALE)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings),
    .hold     (hold)
  );

  mups_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .element    (element),
    .settings   (settings),
    .hold       (hold),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mups_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mups_back #(
    .MAX_DIM   (MAX_DIM),
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .settings  (settings),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .scatter   (scatter)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the max-unpool scatter address generator.
module tb_top;
  import mups_pkg::*;

  localparam int MAX_GAP      = 13;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 1000;
  localparam int END_CYCLES   = 40;
  localparam int RANDOM_ITEMS = 680;
  localparam int MAX_REPORTS  = 50;
  localparam int FIRST_UNUSED_REG = int'(REG_RELATIVE_MODE) + 1;
  localparam longint unsigned ADDR_ALL_ONES = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic              oor;
    logic              last;
  } scatter_write_t;

  logic clk;
  logic rst;

  mups_cfg_if cfg_bus ();
  mups_in_if  element_bus ();
  mups_out_if scatter_bus ();

  max_unpool_scatter_address #(
    .MAX_DIM   (DEF_MAX_DIM),
    .MAX_SCALE (DEF_MAX_SCALE)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .element (element_bus),
    .scatter (scatter_bus)
  );

  // Register shadow and raster position of the predictor
  logic [DIM_REG_W-1:0]   cur_in_width;
  logic [DIM_REG_W-1:0]   cur_in_height;
  logic [BIG_REG_W-1:0]   cur_plane_count;
  logic [BIG_REG_W-1:0]   cur_out_width;
  logic [BIG_REG_W-1:0]   cur_out_height;
  logic [SCALE_REG_W-1:0] cur_scale_x;
  logic [SCALE_REG_W-1:0] cur_scale_y;
  logic                   cur_relative;
  longint unsigned        col_pos, row_pos, plane_pos, plane_base_addr;

  scatter_write_t pending_writes[$];
  int  mismatch_count = 0;
  bit  in_idle_en     = 1'b1;
  bit  out_idle_en    = 1'b1;
  bit  hold_output    = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned clamp_u(longint unsigned v, longint unsigned lo,
                                              longint unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Compute the scatter write for one element and advance the raster position
  function automatic scatter_write_t predict_scatter(logic [DATA_W-1:0] v,
                                                     logic [IDX_W-1:0] idx);
    longint unsigned iw, ih, pc, ow, oh, sx, sy, ix, orow, ocol, addr, nb;
    logic bad, end_col, end_row, end_pln;
    scatter_write_t w;
    iw = clamp_u(cur_in_width, 1, DEF_MAX_DIM);
    ih = clamp_u(cur_in_height, 1, DEF_MAX_DIM);
    pc = clamp_u(cur_plane_count, 1, PLANE_LIMIT);
    ow = clamp_u(cur_out_width, 1, PLANE_LIMIT);
    oh = clamp_u(cur_out_height, 1, PLANE_LIMIT);
    sx = clamp_u(cur_scale_x, 1, DEF_MAX_SCALE);
    sy = clamp_u(cur_scale_y, 1, DEF_MAX_SCALE);
    ix = idx;
    end_col = (col_pos + 1 >= iw);
    end_row = (row_pos + 1 >= ih);
    end_pln = (plane_pos + 1 >= pc);
    if (cur_relative) begin
      orow = row_pos * sy + ix / sx;
      ocol = col_pos * sx + ix % sx;
      addr = plane_base_addr + orow * ow + ocol;
      bad  = (ix >= sx * sy) || (ocol >= ow) || (orow >= oh);
    end else begin
      addr = ix;
      bad  = (ix >= pc * ow * oh);
    end
    if (addr > ADDR_ALL_ONES) addr = ADDR_ALL_ONES;
    w.addr  = addr[ADDR_W-1:0];
    w.value = v;
    w.oor   = bad;
    w.last  = end_col && end_row && end_pln;

    // Advance column, then row, then plane; a counter at or past its limit wraps
    if (!end_col) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (!end_row) begin
        row_pos++;
      end else begin
        row_pos = 0;
        if (!end_pln) begin
          nb = plane_base_addr + ow * oh;
          plane_pos++;
          plane_base_addr = (nb > ADDR_ALL_ONES) ? ADDR_ALL_ONES : nb;
        end else begin
          plane_pos       = 0;
          plane_base_addr = 0;
        end
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // Write one register; entered and left at a falling edge
  task automatic set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (index)
      REG_IN_WIDTH:      cur_in_width    = data[DIM_REG_W-1:0];
      REG_IN_HEIGHT:     cur_in_height   = data[DIM_REG_W-1:0];
      REG_PLANE_COUNT:   cur_plane_count = data[BIG_REG_W-1:0];
      REG_OUT_WIDTH:     cur_out_width   = data[BIG_REG_W-1:0];
      REG_OUT_HEIGHT:    cur_out_height  = data[BIG_REG_W-1:0];
      REG_SCALE_X:       cur_scale_x     = data[SCALE_REG_W-1:0];
      REG_SCALE_Y:       cur_scale_y     = data[SCALE_REG_W-1:0];
      REG_RELATIVE_MODE: cur_relative    = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Fill bits above the register width with noise now and then
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w,
                                                      bit junk);
    if (junk && $urandom_range(0, 3) == 0) return v | (CFG_DATA_W'($urandom) << w);
    return v;
  endfunction

  task automatic apply_config(logic [31:0] iw, logic [31:0] ih, logic [31:0] pc,
                              logic [31:0] ow, logic [31:0] oh, logic [31:0] sx,
                              logic [31:0] sy, logic rel, bit junk);
    set_register(REG_IN_WIDTH,      with_junk(iw, DIM_REG_W, junk));
    set_register(REG_IN_HEIGHT,     with_junk(ih, DIM_REG_W, junk));
    set_register(REG_PLANE_COUNT,   with_junk(pc, BIG_REG_W, junk));
    set_register(REG_OUT_WIDTH,     with_junk(ow, BIG_REG_W, junk));
    set_register(REG_OUT_HEIGHT,    with_junk(oh, BIG_REG_W, junk));
    set_register(REG_SCALE_X,       with_junk(sx, SCALE_REG_W, junk));
    set_register(REG_SCALE_Y,       with_junk(sy, SCALE_REG_W, junk));
    set_register(REG_RELATIVE_MODE, with_junk(32'(rel), 1, junk));
    if (junk && $urandom_range(0, 3) == 0)
      set_register(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, 2**CFG_IDX_W - 1)), $urandom);
    cfg_bus.valid <= 1'b0;
  endtask

  // Offer one element; valid stays high on return so a zero gap keeps streaming
  task automatic send_element(logic [DATA_W-1:0] v, logic [IDX_W-1:0] idx);
    int gap;
    gap = in_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      element_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    element_bus.valid      <= 1'b1;
    element_bus.value      <= v;
    element_bus.pool_index <= idx;
    do @(posedge clk); while (!element_bus.ready);
    pending_writes.push_back(predict_scatter(v, idx));
    @(negedge clk);
  endtask

  // Drop valid and wait until every pending write has come out
  task automatic wait_drained();
    element_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic check_write();
    scatter_write_t want;
    if (pending_writes.size() == 0) begin
      report_mismatch("write with no pending element", scatter_bus.write_address, 0);
    end else begin
      want = pending_writes.pop_front();
      if (scatter_bus.write_address !== want.addr)
        report_mismatch("write_address", scatter_bus.write_address, want.addr);
      if (scatter_bus.write_value !== want.value)
        report_mismatch("write_value", scatter_bus.write_value, want.value);
      if (scatter_bus.out_of_range !== want.oor)
        report_mismatch("out_of_range", scatter_bus.out_of_range, want.oor);
      if (scatter_bus.last !== want.last)
        report_mismatch("last", scatter_bus.last, want.last);
    end
  endtask

  // Scatter write sink: random stalls, one long hold-off on request
  initial begin : scatter_sink
    int gap;
    scatter_bus.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (hold_output) begin
        gap = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        gap = out_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap > 0) begin
        scatter_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      scatter_bus.ready <= 1'b1;
      do @(posedge clk); while (!scatter_bus.valid);
      check_write();
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cfg_bus.valid && cfg_bus.ready) || (element_bus.valid && element_bus.ready) ||
          (scatter_bus.valid && scatter_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Reset values: one column, one row, one plane, 1x1 output, 2x2 window
  task automatic test_reset_defaults();
    send_element('0, 0);
    send_element('1, 1);
  endtask

  // Window positions, out-of-window index and output edge overflow in relative mode
  task automatic test_relative_window();
    wait_drained();
    apply_config(2, 2, 2, 3, 3, 2, 2, 1'b1, 1'b0);
    send_element($urandom, 0);
    send_element($urandom, 1);
    send_element($urandom, 2);
    send_element($urandom, 3);
    send_element('1, 4);
    send_element($urandom, 3);
    send_element('0, '1);
    send_element($urandom, 2);
  endtask

  // Absolute addressing against the total output size
  task automatic test_absolute_mode();
    wait_drained();
    apply_config(2, 2, 2, 3, 3, 2, 2, 1'b0, 1'b0);
    send_element($urandom, 17);
    send_element($urandom, 18);
    send_element($urandom, 0);
    send_element($urandom, '1);
  endtask

  // Zero and oversized register values act clamped; unused index is ignored
  task automatic test_register_clamping();
    wait_drained();
    set_register(CFG_IDX_W'(FIRST_UNUSED_REG), '1);
    apply_config(0, (1 << DIM_REG_W) - 1, 0, (1 << BIG_REG_W) - 1, 0,
                 (1 << SCALE_REG_W) - 1, 0, 1'b1, 1'b0);
    send_element($urandom, 15);
    send_element($urandom, 16);
    send_element($urandom, 255);
  endtask

  // Largest output planes: plane base and address saturate at all ones
  task automatic test_plane_base_saturation();
    wait_drained();
    apply_config(1, 1, 3, PLANE_LIMIT, PLANE_LIMIT, 1, 1, 1'b1, 1'b0);
    send_element($urandom, 0);
    send_element($urandom, 0);
    send_element($urandom, 1);
    send_element($urandom, 0);
  endtask

  // Hold the sink off while the source keeps streaming so the input stalls
  task automatic test_output_backpressure();
    wait_drained();
    apply_config(3, 2, 2, 6, 4, 2, 2, 1'b1, 1'b0);
    in_idle_en  = 1'b0;
    hold_output = 1'b1;
    repeat (16) send_element($urandom, $urandom_range(0, 3));
    in_idle_en = 1'b1;
  endtask

  function automatic logic [31:0] pick_size(int w, int typical_hi);
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return (1 << w) - 1;
      2:       return $urandom_range(0, (1 << w) - 1);
      3:       return 1 << (w - 1);
      default: return $urandom_range(1, typical_hi);
    endcase
  endfunction

  function automatic logic [31:0] pick_out_size(longint unsigned fitted);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return (1 << BIG_REG_W) - 1;
      2:       return $urandom_range(0, (1 << BIG_REG_W) - 1);
      3:       return 32'(fitted - 1);
      default: return 32'(fitted);
    endcase
  endfunction

  // Phases of random settings, mostly well-formed indexes with some noise
  task automatic test_random_stream();
    int sent, n;
    logic [31:0] iw, ih, pc, sx, sy;
    logic rel;
    longint unsigned window, bound, lim;
    logic [IDX_W-1:0] idx;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      iw  = pick_size(DIM_REG_W, 5);
      ih  = pick_size(DIM_REG_W, 4);
      pc  = pick_size(BIG_REG_W, 3);
      sx  = pick_size(SCALE_REG_W, 4);
      sy  = pick_size(SCALE_REG_W, 4);
      rel = ($urandom_range(0, 9) < 7);
      apply_config(iw, ih, pc,
                   pick_out_size(clamp_u(iw, 1, DEF_MAX_DIM) * clamp_u(sx, 1, DEF_MAX_SCALE)),
                   pick_out_size(clamp_u(ih, 1, DEF_MAX_DIM) * clamp_u(sy, 1, DEF_MAX_SCALE)),
                   sx, sy, rel, 1'b1);
      in_idle_en  = $urandom_range(0, 1);
      out_idle_en = $urandom_range(0, 1);
      window = clamp_u(cur_scale_x, 1, DEF_MAX_SCALE) * clamp_u(cur_scale_y, 1, DEF_MAX_SCALE);
      bound  = clamp_u(cur_plane_count, 1, PLANE_LIMIT) * clamp_u(cur_out_width, 1, PLANE_LIMIT)
               * clamp_u(cur_out_height, 1, PLANE_LIMIT);
      lim    = (bound - 1 > ADDR_ALL_ONES) ? ADDR_ALL_ONES : bound - 1;
      n = $urandom_range(30, 70);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0:       idx = $urandom;
          1:       idx = cur_relative ? IDX_W'(window + $urandom_range(0, 3))
                                      : IDX_W'(bound - 1 + $urandom_range(0, 2));
          default: idx = cur_relative ? IDX_W'($urandom_range(0, 32'(window - 1)))
                                      : IDX_W'($urandom_range(0, 32'(lim)));
        endcase
        send_element($urandom, idx);
      end
      sent += n;
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Main sequence
  initial begin
    rst                    = 1'b1;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
    element_bus.valid      = 1'b0;
    element_bus.value      = '0;
    element_bus.pool_index = '0;
    cur_in_width    = 1;
    cur_in_height   = 1;
    cur_plane_count = 1;
    cur_out_width   = 1;
    cur_out_height  = 1;
    cur_scale_x     = 2;
    cur_scale_y     = 2;
    cur_relative    = 1'b1;
    col_pos         = 0;
    row_pos         = 0;
    plane_pos       = 0;
    plane_base_addr = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_relative_window();
    test_absolute_mode();
    test_register_clamping();
    test_plane_base_saturation();
    test_output_backpressure();
    test_random_stream();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0)
      report_mismatch("writes still pending", pending_writes.size(), 0);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
